// ----- sv/tod_pkg.sv -----
// Shared types, constants and a helper function for the time-of-day clock.
package tod_pkg;

  // Operation codes; any other code behaves as a read
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Counter limits
  localparam logic [5:0] SECOND_MAX   = 6'd59;
  localparam logic [5:0] MINUTE_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX     = 5'd23;
  localparam logic [4:0] HOUR_NOON    = 5'd12;
  localparam logic [3:0] HOUR12_MAX   = 4'd12;
  localparam logic [4:0] HOUR_PM_OFS  = 5'd12;
  localparam logic [2:0] WEEKDAY_MAX  = 3'd6;
  localparam logic [7:0] TPS_RESET    = 8'd9;

  // floor(x * 167 / 100) == (x * 167 * 5243) >> 19, exact for 6-bit x
  localparam logic [19:0] SCALE_MUL   = 20'd875581;
  localparam int          SCALE_SHIFT = 19;

  // Input item
  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] set_weekday;
    logic [3:0] set_hour;
    logic [5:0] set_minute;
    logic       set_pm;
  } tod_item_t;

  // Result item
  typedef struct packed {
    logic [3:0] hour_twelve;
    logic [4:0] hour_day;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic       pm_now;
    logic [2:0] weekday_now;
    logic [6:0] minute_scaled;
    logic [6:0] second_scaled;
    logic       new_day;
    logic       set_rejected;
  } tod_result_t;

  // Time after an item has been applied, passed from core to readout
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       pm;
    logic [2:0] weekday;
    logic       new_day;
    logic       set_rejected;
  } tod_time_t;

  // Scaled minute/second readout by constant reciprocal multiply
  function automatic logic [6:0] scale167(input logic [5:0] x);
    logic [25:0] prod;
    prod = {20'd0, x} * {6'd0, SCALE_MUL};
    return prod[SCALE_SHIFT +: 7];
  endfunction

endpackage

// ----- sv/tod_core.sv -----
// Time-keeping state, tick cascade, time load and the ticks-per-second register.
module tod_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  input  logic               item_fire,
  input  tod_pkg::tod_item_t item,
  output tod_pkg::tod_time_t time_next
);
  import tod_pkg::*;

  logic [7:0] ticks_per_second;
  logic [7:0] tick_count;
  logic [5:0] second_count;
  logic [5:0] minute_count;
  logic [4:0] hour_count;
  logic [2:0] weekday_count;
  logic       pm_flag;

  logic [7:0] tick_count_next;
  logic [5:0] second_count_next;
  logic [5:0] minute_count_next;
  logic [4:0] hour_count_next;
  logic [2:0] weekday_count_next;
  logic       pm_flag_next;
  logic       rolled;
  logic       rejected;

  logic [8:0] tick_inc;
  logic [4:0] hour_inc;
  logic       set_ok;

  // Next state for one item
  always_comb begin
    tick_count_next    = tick_count;
    second_count_next  = second_count;
    minute_count_next  = minute_count;
    hour_count_next    = hour_count;
    weekday_count_next = weekday_count;
    pm_flag_next       = pm_flag;
    rolled             = 1'b0;
    rejected           = 1'b0;

    tick_inc = {1'b0, tick_count} + 9'd1;
    hour_inc = hour_count + 5'd1;
    set_ok   = (item.set_hour != 4'd0) && (item.set_hour <= HOUR12_MAX) &&
               (item.set_minute <= MINUTE_MAX);

    case (item.operation)
      OP_TICK: begin
        if (tick_inc >= {1'b0, ticks_per_second}) begin
          tick_count_next = 8'd0;
          if (second_count >= SECOND_MAX) begin
            second_count_next = 6'd0;
            if (minute_count >= MINUTE_MAX) begin
              minute_count_next = 6'd0;
              if (hour_count >= HOUR_MAX) begin
                // midnight: new day
                hour_count_next    = 5'd0;
                pm_flag_next       = 1'b0;
                weekday_count_next = (weekday_count >= WEEKDAY_MAX) ? 3'd0
                                                                    : weekday_count + 3'd1;
                rolled             = 1'b1;
              end else begin
                hour_count_next = hour_inc;
                if (hour_inc >= HOUR_NOON) pm_flag_next = 1'b1;
              end
            end else begin
              minute_count_next = minute_count + 6'd1;
            end
          end else begin
            second_count_next = second_count + 6'd1;
          end
        end else begin
          tick_count_next = tick_inc[7:0];
        end
      end
      OP_SET: begin
        if (set_ok) begin
          weekday_count_next = item.set_weekday;
          if (item.set_hour == HOUR12_MAX && !item.set_pm)
            hour_count_next = 5'd0;
          else if (item.set_hour < HOUR12_MAX && item.set_pm)
            hour_count_next = {1'b0, item.set_hour} + HOUR_PM_OFS;
          else
            hour_count_next = {1'b0, item.set_hour};
          minute_count_next = item.set_minute;
          second_count_next = 6'd0;
          tick_count_next   = 8'd0;
          pm_flag_next      = item.set_pm;
        end else begin
          rejected = 1'b1;
        end
      end
      default: begin
        // read: state unchanged
      end
    endcase
  end

  // Time as seen by this item's result
  assign time_next = '{hour:         hour_count_next,
                       minute:       minute_count_next,
                       second:       second_count_next,
                       pm:           pm_flag_next,
                       weekday:      weekday_count_next,
                       new_day:      rolled,
                       set_rejected: rejected};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (cfg_valid) begin
      ticks_per_second <= cfg_data;
    end
  end

  // Time-keeping state, updated on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= 8'd0;
      second_count  <= 6'd0;
      minute_count  <= 6'd0;
      hour_count    <= 5'd0;
      weekday_count <= 3'd0;
      pm_flag       <= 1'b0;
    end else if (item_fire) begin
      tick_count    <= tick_count_next;
      second_count  <= second_count_next;
      minute_count  <= minute_count_next;
      hour_count    <= hour_count_next;
      weekday_count <= weekday_count_next;
      pm_flag       <= pm_flag_next;
    end
  end

endmodule

// ----- sv/tod_view.sv -----
// Readout formatting: 12-hour form and scaled minute/second values.
module tod_view (
  input  tod_pkg::tod_time_t   time_in,
  output tod_pkg::tod_result_t result_out
);
  import tod_pkg::*;

  logic [3:0] hour12;

  // 0 shows as 12, hours above 12 drop by 12
  always_comb begin
    if (time_in.hour == 5'd0)
      hour12 = HOUR12_MAX;
    else if (time_in.hour > HOUR_NOON)
      hour12 = 4'(time_in.hour - HOUR_PM_OFS);
    else
      hour12 = time_in.hour[3:0];
  end

  assign result_out = '{hour_twelve:   hour12,
                        hour_day:      time_in.hour,
                        minute_now:    time_in.minute,
                        second_now:    time_in.second,
                        pm_now:        time_in.pm,
                        weekday_now:   time_in.weekday,
                        minute_scaled: scale167(time_in.minute),
                        second_scaled: scale167(time_in.second),
                        new_day:       time_in.new_day,
                        set_rejected:  time_in.set_rejected};

endmodule

// ----- sv/tod_obuf.sv -----
// Two-entry result buffer: output register plus skid register.
module tod_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tod_pkg::tod_result_t push_data,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tod_pkg::tod_result_t out_data
);
  import tod_pkg::*;

  logic        skid_valid;
  tod_result_t skid_data;

  // Space is known from registered state only
  assign can_push = !skid_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (out_valid && !out_ready && push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- sv/time_of_day_clock.sv -----
// Top level of the time-of-day clock with weekday and 12/24-hour readout.
//
// Item channel (item_valid/item_ready/item): each transfer is a tick, a time
// set or a read. Every item produces exactly one result on the result channel
// (result_valid/result_ready/result) showing the time after the item applies.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes ticks_per_second; it is
// always ready and should only be written while no results are outstanding.
//
// Latency: with the output register free, a result is presented on
// result_valid the cycle after its item transfer; behind a stalled result it
// waits in the second entry. Throughput: one item per clock while item_ready is
// high; the whole tick carry chain and the set conversion are combinational
// ahead of the result register.
// A two-entry output buffer sits before the result port; item_ready drops only
// when both entries hold results the receiver has stalled on, and it comes
// from a register, so there is no path from result_ready to item_ready.
//
// Reset (synchronous): time is 00:00:00 AM on Sunday, sub-second count zero,
// ticks_per_second 9, output buffer empty.
module time_of_day_clock (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tod_pkg::tod_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output tod_pkg::tod_result_t result
);
  import tod_pkg::*;

  logic        item_fire;
  tod_time_t   time_next;
  tod_result_t result_next;

  assign cfg_ready = 1'b1;
  assign item_fire = item_valid && item_ready;

  // State and next-time logic
  tod_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .item_fire (item_fire),
    .item      (item),
    .time_next (time_next)
  );

  // Result formatting
  tod_view u_view (
    .time_in    (time_next),
    .result_out (result_next)
  );

  // Output buffering
  tod_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (item_fire),
    .push_data (result_next),
    .can_push  (item_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

endmodule

// ----- sv/tod_checker.sv -----
// Port-level checker for the time-of-day clock, bound to the top level.
module tod_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input tod_pkg::tod_result_t result
);
  import tod_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Input only stalls while a result is waiting
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("input stalled with no result pending");

  // Meridiem follows the 24-hour value
  a_pm: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.pm_now == (result.hour_day >= HOUR_NOON)))
    else $error("pm flag disagrees with hour");

  // 12-hour and 24-hour forms agree
  a_h12: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      ((result.hour_day == 5'd0 && result.hour_twelve == HOUR12_MAX) ||
       (result.hour_day != 5'd0 && result.hour_day <= HOUR_NOON &&
        {1'b0, result.hour_twelve} == result.hour_day) ||
       (result.hour_day > HOUR_NOON &&
        {1'b0, result.hour_twelve} + HOUR_PM_OFS == result.hour_day)))
    else $error("12-hour readout mismatch");

  // A new day shows midnight and never comes with a rejected set
  a_newday: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.new_day |->
      result.hour_day == 5'd0 && result.minute_now == 6'd0 &&
      result.second_now == 6'd0 && !result.set_rejected)
    else $error("new day without midnight");

endmodule

bind time_of_day_clock tod_checker u_tod_checker (.*);

// ----- tb/sv/time_of_day_clock_tb.sv -----
// Self-checking testbench for the time-of-day clock: directed items, then random traffic.
module time_of_day_clock_tb;
  import tod_pkg::*;

  // Code 3 has no name in the package; the block treats it as a read
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 120000;
  localparam int MAX_REPORTS = 10;

  // Tracks the clock state and holds the readouts still due from the block
  class tod_tracker;
    bit [7:0] rate;
    bit [7:0] tick_cnt;
    bit [5:0] sec;
    bit [5:0] min;
    bit [4:0] hour;
    bit [2:0] wday;
    bit       pm;
    tod_result_t readouts_due[$];
    int mismatches;
    int checked;

    function new();
      rate = TPS_RESET;
    endfunction

    function void set_rate(bit [7:0] v);
      rate = v;
    endfunction

    function int pending();
      return readouts_due.size();
    endfunction

    // One sub-second tick; returns 1 when midnight was passed
    function bit advance_tick();
      bit rolled;
      rolled = 1'b0;
      // a rate of zero or one below the count wraps at once
      if (int'(tick_cnt) + 1 >= int'(rate)) begin
        tick_cnt = '0;
        sec++;
        if (sec > SECOND_MAX) begin
          sec = '0;
          min++;
          if (min > MINUTE_MAX) begin
            min = '0;
            hour++;
            if (hour >= HOUR_NOON) pm = 1'b1;
            if (hour > HOUR_MAX) begin
              hour = '0;
              pm = 1'b0;
              // a weekday of seven, loaded by a set, wraps to Sunday too
              wday = (wday >= WEEKDAY_MAX) ? 3'd0 : wday + 3'd1;
              rolled = 1'b1;
            end
          end
        end
      end else begin
        tick_cnt++;
      end
      return rolled;
    endfunction

    // Load a 12-hour time; returns 0 and keeps the state when out of range
    function bit load_time(tod_item_t it);
      if (it.set_hour == 4'd0 || it.set_hour > HOUR12_MAX || it.set_minute > MINUTE_MAX)
        return 1'b0;
      wday = it.set_weekday;
      if (it.set_hour == HOUR12_MAX && !it.set_pm) hour = '0;
      else if (it.set_hour < HOUR12_MAX && it.set_pm) hour = {1'b0, it.set_hour} + HOUR_PM_OFS;
      else hour = {1'b0, it.set_hour};
      min = it.set_minute;
      sec = '0;
      tick_cnt = '0;
      pm = it.set_pm;
      return 1'b1;
    endfunction

    function bit [6:0] scaled(bit [5:0] x);
      int prod;
      prod = int'(x) * 167 / 100;
      return prod[6:0];
    endfunction

    // Apply an accepted item and queue the readout it must produce
    function void take_item(tod_item_t it);
      tod_result_t r;
      bit [4:0] h12;
      bit rolled;
      bit rejected;
      rolled = 1'b0;
      rejected = 1'b0;
      case (it.operation)
        OP_TICK: rolled = advance_tick();
        OP_SET:  rejected = !load_time(it);
        default: ;  // read, or the unused code
      endcase
      if (hour == 5'd0) h12 = {1'b0, HOUR12_MAX};
      else if (hour > HOUR_NOON) h12 = hour - HOUR_PM_OFS;
      else h12 = hour;
      r.hour_twelve   = h12[3:0];
      r.hour_day      = hour;
      r.minute_now    = min;
      r.second_now    = sec;
      r.pm_now        = pm;
      r.weekday_now   = wday;
      r.minute_scaled = scaled(min);
      r.second_scaled = scaled(sec);
      r.new_day       = rolled;
      r.set_rejected  = rejected;
      readouts_due.push_back(r);
    endfunction

    function string show(tod_result_t r);
      return $sformatf("%0d:%0d:%0d pm=%0d h24=%0d wd=%0d msc=%0d ssc=%0d nd=%0d rej=%0d",
                       r.hour_twelve, r.minute_now, r.second_now, r.pm_now, r.hour_day,
                       r.weekday_now, r.minute_scaled, r.second_scaled, r.new_day,
                       r.set_rejected);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Compare one accepted readout with the oldest one due
    function void check_readout(tod_result_t got);
      tod_result_t want;
      bit bad;
      checked++;
      if (readouts_due.size() == 0) begin
        note_mismatch($sformatf("result %0d with nothing due: %s", checked, show(got)));
        return;
      end
      want = readouts_due.pop_front();
      bad = (got.hour_twelve !== want.hour_twelve) || (got.hour_day !== want.hour_day) ||
            (got.minute_now !== want.minute_now) || (got.second_now !== want.second_now) ||
            (got.pm_now !== want.pm_now) || (got.weekday_now !== want.weekday_now) ||
            (got.minute_scaled !== want.minute_scaled) ||
            (got.second_scaled !== want.second_scaled) ||
            (got.new_day !== want.new_day) || (got.set_rejected !== want.set_rejected);
      if (bad)
        note_mismatch($sformatf("result %0d expected %s got %s", checked, show(want),
                                show(got)));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        item_valid;
  logic        item_ready;
  tod_item_t   item;
  logic        result_valid;
  logic        result_ready;
  tod_result_t result;

  tod_tracker sb = new();
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  int cycles = 0;

  time_of_day_clock dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("time_of_day_clock_tb failed");
      $finish;
    end
  end

  // Watch every transfer at the rising edge; results before items, since a
  // result never belongs to the item moving in the same cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_readout(result);
      if (item_valid && item_ready) sb.take_item(item);
      if (cfg_valid && cfg_ready) sb.set_rate(cfg_data);
    end
  end

  // Receiver: random stalls, plus long hold-offs counted down here
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_ready <= 1'b0;
        hold_cycles--;
      end else begin
        result_ready <= !(gaps_on && $urandom_range(99) < 12);
      end
    end
  end

  function automatic tod_item_t make_item(logic [1:0] op, logic [2:0] wd, logic [3:0] hr,
                                          logic [5:0] mn, logic pm);
    tod_item_t it;
    it.operation   = op;
    it.set_weekday = wd;
    it.set_hour    = hr;
    it.set_minute  = mn;
    it.set_pm      = pm;
    return it;
  endfunction

  function automatic tod_item_t rand_item();
    return make_item(2'($urandom_range(3)), 3'($urandom_range(7)), 4'($urandom_range(15)),
                     6'($urandom_range(63)), 1'($urandom_range(1)));
  endfunction

  // Offer one item, starting and ending at a falling edge; valid stays high
  // on return, so the caller either offers the next item or drops it
  task automatic send_item(input tod_item_t it);
    if (gaps_on && $urandom_range(99) < 12) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  // Tick or read with junk in the set fields
  task automatic send_op(input logic [1:0] op);
    tod_item_t it;
    it = rand_item();
    it.operation = op;
    send_item(it);
  endtask

  // Stop offering and wait until every readout has come back
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_rate(input logic [7:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_op(OP_READ);
    send_op(OP_UNUSED);
    // twelve AM and twelve PM, weekday extremes, seven on set
    send_item(make_item(OP_SET, 3'd0, HOUR12_MAX, 6'd0, 1'b0));
    send_item(make_item(OP_SET, 3'd6, HOUR12_MAX, 6'd59, 1'b1));
    send_item(make_item(OP_SET, 3'd7, 4'd11, 6'd59, 1'b1));
    // rejected sets (hour zero, hour above twelve, minute above 59), then one valid set
    send_item(make_item(OP_SET, 3'd2, 4'd0, 6'd0, 1'b0));
    send_item(make_item(OP_SET, 3'd3, 4'd13, 6'd10, 1'b1));
    send_item(make_item(OP_SET, 3'd7, 4'd15, 6'd63, 1'b1));
    send_item(make_item(OP_SET, 3'd1, HOUR12_MAX, 6'd60, 1'b0));
    send_item(make_item(OP_SET, 3'd1, 4'd1, 6'd0, 1'b0));
    // one full second at the reset rate
    repeat (9) send_op(OP_TICK);
    wait_idle();
    write_rate(8'd255);
    repeat (3) send_op(OP_TICK);
    // rate dropped below the running count wraps on the next tick
    wait_idle();
    write_rate(8'd2);
    send_op(OP_TICK);
    wait_idle();
    write_rate(8'd0);
    send_op(OP_TICK);
  endtask

  task automatic run_random(input int budget);
    int sent;
    int kind;
    int n;
    tod_item_t it;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // set late in hour eleven (short of noon or midnight) or twelve, then tick on
        it = make_item(OP_SET, 3'($urandom_range(7)),
                       $urandom_range(4) != 0 ? 4'd11 : HOUR12_MAX,
                       6'($urandom_range(58, 59)), 1'($urandom_range(1)));
        send_item(it);
        sent++;
        n = $urandom_range(20, 75);
        if (n > budget - sent) n = budget - sent;
        repeat (n) begin
          send_op($urandom_range(99) < 10 ? OP_READ : OP_TICK);
          sent++;
        end
      end else if (kind < 80) begin
        it = make_item(OP_SET, 3'($urandom_range(7)), 4'($urandom_range(1, 12)),
                       6'($urandom_range(59)), 1'($urandom_range(1)));
        send_item(it);
        sent++;
        n = $urandom_range(5, 30);
        if (n > budget - sent) n = budget - sent;
        repeat (n) begin
          send_op($urandom_range(99) < 10 ? OP_READ : OP_TICK);
          sent++;
        end
      end else begin
        // noise: any operation with any field values
        send_item(rand_item());
        sent++;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    item_valid = 1'b0;
    item       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    // one second per tick, no idling on either side
    wait_idle();
    gaps_on = 1'b0;
    write_rate(8'd1);
    run_random(400);

    // zero rate; receiver holds off long enough to back up the input
    wait_idle();
    gaps_on = 1'b1;
    write_rate(8'd0);
    hold_cycles = 60;
    run_random(150);
    wait_idle();
    run_random(150);

    wait_idle();
    write_rate(8'd2);
    run_random(250);

    wait_idle();
    write_rate(8'd255);
    run_random(150);

    wait_idle();
    write_rate(8'($urandom_range(3, 254)));
    run_random(200);

    wait_idle();
    write_rate(TPS_RESET);
    run_random(150);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("time_of_day_clock_tb passed");
    end else begin
      $display("time_of_day_clock_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tod_pkg.sv
sv/tod_core.sv
sv/tod_view.sv
sv/tod_obuf.sv
sv/time_of_day_clock.sv
sv/tod_checker.sv
tb/sv/time_of_day_clock_tb.sv
